// ===== rtl/core/moving_window_std_deviation_top_macros.svh =====
// Assertion macros for the sliding-window standard deviation block.
`ifndef MOVING_WINDOW_STD_DEVIATION_TOP_MACROS_SVH
`define MOVING_WINDOW_STD_DEVIATION_TOP_MACROS_SVH

// Condition must never hold outside reset.
`define MWSD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MWSD_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/mwsd_pkg.sv =====
// Shared constants, types and state encodings for the window deviation block.
package mwsd_pkg;

  localparam int WIN_SIZE    = 32;
  localparam int WIN_AW      = $clog2(WIN_SIZE);
  localparam int FILL_W      = WIN_AW + 1;
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int SUM_W       = SAMPLE_W + WIN_AW + 1;
  localparam int ABS_W       = SAMPLE_W + WIN_AW;
  localparam int SUMSQ_W     = SQ_W + WIN_AW - 1;
  localparam int SUM2_W      = 2 * ABS_W;
  localparam int DIFF_W      = SUMSQ_W + WIN_AW;
  localparam int Q8_SHIFT    = 16 - 2 * WIN_AW;
  localparam int STD_W       = 24;
  localparam int RAD_W       = 2 * STD_W;
  localparam int REM_W       = STD_W + 3;
  localparam int ROOT_STEPS  = STD_W;
  localparam int CNT_W       = $clog2(ROOT_STEPS);
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  typedef struct packed {
    logic                      valid_res;
    logic signed [SUM_W-1:0]   sum;
    logic [SUMSQ_W-1:0]        sumsq;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUB,
    B_ROOT,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/core/mwsd_if.sv =====
// Sample request and result request channel interfaces.
interface mwsd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwsd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mwsd_result_if;
  logic                              valid;
  logic                              ready;
  logic [mwsd_pkg::STD_W-1:0]        std_dev;
  logic                              valid_res;

  modport source (output valid, output std_dev, output valid_res, input ready);
  modport sink (input valid, input std_dev, input valid_res, output ready);
endinterface

// ===== rtl/core/mwsd_front.sv =====
// Front end: window store, running sum and sum of squares update.
module mwsd_front (
  input  logic                 clk,
  input  logic                 rst,
  mwsd_sample_if.sink          samples,
  input  mwsd_pkg::q_stat_t    q_stat,
  output mwsd_pkg::q_wr_t      q_wr
);

  logic signed [mwsd_pkg::SAMPLE_W-1:0] window_mem [mwsd_pkg::WIN_SIZE];

  mwsd_pkg::front_state_t state, state_next;

  logic signed [mwsd_pkg::SAMPLE_W-1:0] x_r;
  logic signed [mwsd_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [mwsd_pkg::SAMPLE_W-1:0] old_r;
  logic signed [mwsd_pkg::SAMPLE_W-1:0] old_sel;
  logic signed [mwsd_pkg::SQ_W-1:0]     x_wide;
  logic signed [mwsd_pkg::SQ_W-1:0]     old_wide;
  logic [mwsd_pkg::SQ_W-1:0]            sq_x;
  logic [mwsd_pkg::SQ_W-1:0]            sq_old;
  logic                                 warm_r;
  logic [mwsd_pkg::WIN_AW-1:0]          addr_r;
  logic [mwsd_pkg::WIN_AW-1:0]          addr_in;
  logic [mwsd_pkg::WIN_AW-1:0]          wp;
  logic [mwsd_pkg::FILL_W-1:0]          fill;
  logic                                 warm_now;
  logic                                 accept;
  logic signed [mwsd_pkg::SUM_W-1:0]    sum, sum_next;
  logic [mwsd_pkg::SUMSQ_W-1:0]         sumsq, sumsq_next;

  assign warm_now      = fill < mwsd_pkg::FILL_W'(mwsd_pkg::WIN_SIZE);
  assign addr_in       = warm_now ? fill[mwsd_pkg::WIN_AW-1:0] : wp;
  assign samples.ready = (state == mwsd_pkg::F_IDLE) && !q_stat.full;
  assign accept        = samples.valid && samples.ready;
  assign old_sel       = warm_r ? '0 : rd_data;
  assign x_wide        = mwsd_pkg::SQ_W'(x_r);
  assign old_wide      = mwsd_pkg::SQ_W'(old_sel);

  assign sum_next   = sum - mwsd_pkg::SUM_W'(old_r) + mwsd_pkg::SUM_W'(x_r);
  assign sumsq_next = sumsq - mwsd_pkg::SUMSQ_W'(sq_old) + mwsd_pkg::SUMSQ_W'(sq_x);

  always_comb begin
    state_next           = state;
    q_wr.valid           = 1'b0;
    q_wr.data.valid_res  = !warm_r;
    q_wr.data.sum        = sum_next;
    q_wr.data.sumsq      = sumsq_next;
    case (state)
      mwsd_pkg::F_IDLE: begin
        if (accept) state_next = mwsd_pkg::F_MUL;
      end
      mwsd_pkg::F_MUL: begin
        state_next = mwsd_pkg::F_UPD;
      end
      mwsd_pkg::F_UPD: begin
        q_wr.valid = 1'b1;
        state_next = mwsd_pkg::F_IDLE;
      end
      default: begin
        state_next = mwsd_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= window_mem[addr_in];
    end
    if (state == mwsd_pkg::F_MUL) begin
      window_mem[addr_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= samples.sample;
      warm_r <= warm_now;
      addr_r <= addr_in;
    end
    if (state == mwsd_pkg::F_MUL) begin
      old_r  <= old_sel;
      sq_x   <= $unsigned(x_wide * x_wide);
      sq_old <= $unsigned(old_wide * old_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwsd_pkg::F_IDLE;
      sum   <= '0;
      sumsq <= '0;
      fill  <= '0;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (state == mwsd_pkg::F_UPD) begin
        sum   <= sum_next;
        sumsq <= sumsq_next;
        if (warm_r) begin
          fill <= fill + mwsd_pkg::FILL_W'(1);
        end else begin
          wp <= wp + mwsd_pkg::WIN_AW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/mwsd_queue.sv =====
// Short FIFO of window sums between front and back ends.
module mwsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mwsd_pkg::q_wr_t      q_wr,
  input  logic                 pop,
  output mwsd_pkg::entry_t     rd_data,
  output mwsd_pkg::q_stat_t    q_stat
);

  mwsd_pkg::entry_t            slots [mwsd_pkg::Q_DEPTH];
  logic [mwsd_pkg::Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [mwsd_pkg::Q_AW:0]     count;

  assign q_stat.full  = count == (mwsd_pkg::Q_AW+1)'(mwsd_pkg::Q_DEPTH);
  assign q_stat.empty = count == '0;
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      slots[wr_ptr] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.valid) wr_ptr <= wr_ptr + mwsd_pkg::Q_AW'(1);
      if (pop) rd_ptr <= rd_ptr + mwsd_pkg::Q_AW'(1);
      if (q_wr.valid && !pop) begin
        count <= count + (mwsd_pkg::Q_AW+1)'(1);
      end else if (pop && !q_wr.valid) begin
        count <= count - (mwsd_pkg::Q_AW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mwsd_back.sv =====
// Back end: variance numerator and bit-serial square root, result register.
module mwsd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mwsd_pkg::q_stat_t    q_stat,
  input  mwsd_pkg::entry_t     q_data,
  output logic                 pop,
  mwsd_result_if.source        results
);

  mwsd_pkg::back_state_t state, state_next;

  logic signed [mwsd_pkg::SUM_W-1:0] ent_sum;
  logic [mwsd_pkg::SUMSQ_W-1:0]      ent_sumsq;
  logic [mwsd_pkg::SUM_W-1:0]        abs_full;
  logic [mwsd_pkg::ABS_W-1:0]        abs_v;
  logic [mwsd_pkg::SUM2_W-1:0]       sum2;
  logic [mwsd_pkg::DIFF_W-1:0]       lhs;
  logic [mwsd_pkg::DIFF_W-1:0]       diff;
  logic [mwsd_pkg::RAD_W-1:0]        rad;
  logic [mwsd_pkg::REM_W-1:0]        rem, rem_sh, rem_step, trial;
  logic [mwsd_pkg::STD_W-1:0]        root, root_step;
  logic [mwsd_pkg::CNT_W-1:0]        cnt;
  logic                              ge;
  logic                              load;
  logic                              out_valid;
  logic [mwsd_pkg::STD_W-1:0]        out_std;
  logic                              out_vres;
  logic                              ent_vres;

  assign results.valid     = out_valid;
  assign results.std_dev   = out_std;
  assign results.valid_res = out_vres;

  assign abs_full = ent_sum[mwsd_pkg::SUM_W-1] ? $unsigned(-ent_sum) : $unsigned(ent_sum);
  assign abs_v    = abs_full[mwsd_pkg::ABS_W-1:0];
  assign lhs      = {ent_sumsq, {mwsd_pkg::WIN_AW{1'b0}}};
  assign diff     = ({1'b0, lhs} >= sum2) ? lhs - sum2[mwsd_pkg::DIFF_W-1:0] : '0;

  // one result bit per cycle, two radicand bits shifted in
  assign rem_sh    = {rem[mwsd_pkg::REM_W-3:0], rad[mwsd_pkg::RAD_W-1 -: 2]};
  assign trial     = mwsd_pkg::REM_W'({root, 2'b01});
  assign ge        = rem_sh >= trial;
  assign rem_step  = ge ? rem_sh - trial : rem_sh;
  assign root_step = {root[mwsd_pkg::STD_W-2:0], ge};

  assign load = (state == mwsd_pkg::B_DONE) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      mwsd_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = q_data.valid_res ? mwsd_pkg::B_MUL : mwsd_pkg::B_DONE;
        end
      end
      mwsd_pkg::B_MUL: begin
        state_next = mwsd_pkg::B_SUB;
      end
      mwsd_pkg::B_SUB: begin
        state_next = mwsd_pkg::B_ROOT;
      end
      mwsd_pkg::B_ROOT: begin
        if (cnt == mwsd_pkg::CNT_W'(mwsd_pkg::ROOT_STEPS - 1)) begin
          state_next = mwsd_pkg::B_DONE;
        end
      end
      mwsd_pkg::B_DONE: begin
        if (load) state_next = mwsd_pkg::B_IDLE;
      end
      default: begin
        state_next = mwsd_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mwsd_pkg::B_IDLE: begin
        ent_vres  <= q_data.valid_res;
        ent_sum   <= q_data.sum;
        ent_sumsq <= q_data.sumsq;
        root      <= '0;
        rem       <= '0;
      end
      mwsd_pkg::B_MUL: begin
        sum2 <= mwsd_pkg::SUM2_W'(abs_v) * mwsd_pkg::SUM2_W'(abs_v);
      end
      mwsd_pkg::B_SUB: begin
        rad <= mwsd_pkg::RAD_W'({diff, {mwsd_pkg::Q8_SHIFT{1'b0}}});
        cnt <= '0;
      end
      mwsd_pkg::B_ROOT: begin
        rad  <= {rad[mwsd_pkg::RAD_W-3:0], 2'b00};
        rem  <= rem_step;
        root <= root_step;
        cnt  <= cnt + mwsd_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (load) begin
      out_std  <= root;
      out_vres <= ent_vres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwsd_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/moving_window_std_deviation_top.sv =====
// Top level of the sliding-window population standard deviation block.
// Each sample request updates a 32-deep window with its running sum and sum of
// squares and yields one result: std_dev = floor(256*sqrt(32*sumsq - sum^2)/32)
// in unsigned Q.8 with valid_res high once the window is full, or 0 with
// valid_res low for the first 32 samples. The front end takes a sample only when
// idle and the queue is not full, then does the window read, squares and sum
// update in order; the back end forms each full-window result with its 24-step
// bit-serial square root and skips the root for warm-up results. A 4-entry
// queue lets the front accept samples while the back end is busy.
`include "moving_window_std_deviation_top_macros.svh"

module moving_window_std_deviation_top (
  input  logic           clk,
  input  logic           rst,
  mwsd_sample_if.sink    samples,
  mwsd_result_if.source  results
);

  mwsd_pkg::q_wr_t    q_wr;
  mwsd_pkg::q_stat_t  q_stat;
  mwsd_pkg::entry_t   q_data;
  logic               q_pop;

  mwsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_stat  (q_stat),
    .q_wr    (q_wr)
  );

  mwsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .pop     (q_pop),
    .rd_data (q_data),
    .q_stat  (q_stat)
  );

  mwsd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .q_data  (q_data),
    .pop     (q_pop),
    .results (results)
  );

  `MWSD_NEVER(a_queue_overflow, q_wr.valid && q_stat.full, "queue push while full")
  `MWSD_NEVER(a_queue_underflow, q_pop && q_stat.empty, "queue pop while empty")
  `MWSD_IMPLY(a_warm_zero, results.valid && !results.valid_res, results.std_dev == '0, "warm-up result not zero")

endmodule
